FILE: design/stepper_segment_ramp_generator_top_macros.svh
// ----------------------------------------------------------------------------
// stepper segment ramp generator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef STEPPER_SEGMENT_RAMP_GENERATOR_TOP_MACROS_SVH
`define STEPPER_SEGMENT_RAMP_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define SSRG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssrg same-cycle check failed");

// next-cycle implication
`define SSRG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssrg next-cycle check failed");

`endif

FILE: design/ssrg_pkg.sv
// ----------------------------------------------------------------------------
// ssrg_pkg
// types and constants of the stepper segment ramp generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssrg_pkg;

    localparam int MOTORS      = 8;
    localparam int DELAY_SHIFT = 5;
    localparam int DATA_W      = 32;
    localparam int STEP_W      = 8;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [1:0] CMD_LOAD_RATE = 2'd0;
    localparam logic [1:0] CMD_START     = 2'd1;
    localparam logic [1:0] CMD_STEP      = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [2:0]        motor_select;
        logic [DATA_W-1:0] motor_rate_value;
        logic              skip_segment;
        logic [DATA_W-1:0] accel_count;
        logic [DATA_W-1:0] cruise_count;
        logic [DATA_W-1:0] decel_count;
        logic [DATA_W-1:0] cruise_delay_value;
        logic [DATA_W-1:0] start_period;
        logic [DATA_W-1:0] start_index;
    } item_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_bits;
        logic [DATA_W-1:0] delay_cycles;
        logic              segment_done;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_DONE,
        MODE_ACCEL,
        MODE_CRUISE,
        MODE_DECEL
    } mode_t;

endpackage

FILE: design/stepper_segment_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// stepper_segment_ramp_generator_top
// multi-axis dda step generator with an accel / cruise / decel period ramp
// ----------------------------------------------------------------------------
//
//  channel   signals                          dir  transfer when
//  item      item_valid, item_ready, item     in   item_valid && item_ready
//  result    result_valid, result_ready, res  out  result_valid && result_ready
//
//  rate load and segment start finish in the accepting cycle
//  a step loop in cruise, done, or accel at ramp index zero goes from accept straight to emit
//  a ramp step runs accept, then 32 passes of the restoring divider, then emit
//  the shared 33-bit subtract/compare in the divider sets the ramp step length
//  reset clears all rates, accumulators, counts and the ramp state to zero
//  emit holds while the output register is full and result_ready is low; item_ready is low until then
//
`timescale 1ns / 1ps

module stepper_segment_ramp_generator_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ssrg_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output ssrg_pkg::result_t result
);
    import ssrg_pkg::*;

    // control and ramp state
    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic              div_used_reg, div_used_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic              result_valid_reg, result_valid_next;

    logic [DATA_W-1:0] phase_acc_reg [MOTORS];
    logic [DATA_W-1:0] phase_acc_next [MOTORS];
    logic [DATA_W-1:0] motor_rate_reg [MOTORS];
    logic [DATA_W-1:0] motor_rate_next [MOTORS];
    logic [DATA_W-1:0] ramp_remainder_reg, ramp_remainder_next;
    logic [DATA_W-1:0] ramp_period_reg, ramp_period_next;
    logic [DATA_W-1:0] ramp_index_reg, ramp_index_next;
    logic [DATA_W-1:0] accel_left_reg, accel_left_next;
    logic [DATA_W-1:0] cruise_left_reg, cruise_left_next;
    logic [DATA_W-1:0] decel_left_reg, decel_left_next;
    logic [DATA_W-1:0] cruise_delay_reg, cruise_delay_next;

    // divider working registers and result payload
    logic [DATA_W-1:0] div_rem_reg, div_rem_next;
    logic [DATA_W-1:0] div_quo_reg, div_quo_next;
    logic [DATA_W-1:0] div_dsr_reg, div_dsr_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    result_t           result_reg, result_next;

    // datapath helpers
    logic              accept;
    logic              out_free;
    logic              all_zero;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   trial_diff;
    logic [DATA_W-1:0] quo_used;
    logic [DATA_W-1:0] period_accel;
    logic [DATA_W-1:0] period_decel;
    logic [DATA_W-1:0] acc_sum [MOTORS];

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign all_zero = (accel_left_reg == '0) && (cruise_left_reg == '0)
                      && (decel_left_reg == '0);

    // ramp dividend is shared by both ramp directions
    assign dividend = {ramp_period_reg[DATA_W-2:0], 1'b0} + ramp_remainder_reg;

    // one restoring divide step per cycle: shift in the next dividend bit
    assign trial      = {div_rem_reg, div_quo_reg[DATA_W-1]};
    assign trial_diff = trial - {1'b0, div_dsr_reg};

    // accel at ramp index zero skips the divide and leaves the period alone
    assign quo_used     = div_used_reg ? div_quo_reg : '0;
    assign period_accel = ramp_period_reg - quo_used;
    assign period_decel = ramp_period_reg + quo_used;

    always_comb
    begin
        for (int i = 0; i < MOTORS; i++)
        begin
            acc_sum[i] = phase_acc_reg[i] + motor_rate_reg[i];
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next          = state_reg;
        mode_next           = mode_reg;
        div_used_next       = div_used_reg;
        div_cnt_next        = div_cnt_reg;
        result_valid_next   = result_valid_reg;
        ramp_remainder_next = ramp_remainder_reg;
        ramp_period_next    = ramp_period_reg;
        ramp_index_next     = ramp_index_reg;
        accel_left_next     = accel_left_reg;
        cruise_left_next    = cruise_left_reg;
        decel_left_next     = decel_left_reg;
        cruise_delay_next   = cruise_delay_reg;
        div_rem_next        = div_rem_reg;
        div_quo_next        = div_quo_reg;
        div_dsr_next        = div_dsr_reg;
        steps_next          = steps_reg;
        result_next         = result_reg;
        for (int i = 0; i < MOTORS; i++)
        begin
            phase_acc_next[i]  = phase_acc_reg[i];
            motor_rate_next[i] = motor_rate_reg[i];
        end

        // output register drains on its transfer
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        CMD_LOAD_RATE:
                        begin
                            // motor_select is 3 bits wide, so every value matches exactly one of the eight lanes
                            for (int i = 0; i < MOTORS; i++)
                            begin
                                if (item.motor_select == 3'(i))
                                begin
                                    motor_rate_next[i] = item.motor_rate_value;
                                end
                            end
                        end
                        CMD_START:
                        begin
                            // skip_segment leaves everything as it is
                            if (!item.skip_segment)
                            begin
                                accel_left_next     = item.accel_count;
                                cruise_left_next    = item.cruise_count;
                                decel_left_next     = item.decel_count;
                                cruise_delay_next   = item.cruise_delay_value;
                                ramp_period_next    = item.start_period;
                                ramp_index_next     = item.start_index;
                                ramp_remainder_next = '0;
                                for (int i = 0; i < MOTORS; i++)
                                begin
                                    phase_acc_next[i] = '0;
                                end
                            end
                        end
                        CMD_STEP:
                        begin
                            if (all_zero)
                            begin
                                mode_next  = MODE_DONE;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                // dda lanes advance and report their top bits
                                steps_next = '0;
                                for (int i = 0; i < MOTORS; i++)
                                begin
                                    phase_acc_next[i] = acc_sum[i];
                                    if (i < STEP_W)
                                    begin
                                        steps_next[i] = acc_sum[i][DATA_W-1];
                                    end
                                end

                                // first phase with loops left runs
                                if (accel_left_reg != '0)
                                begin
                                    mode_next     = MODE_ACCEL;
                                    div_used_next = (ramp_index_reg != '0);
                                    div_dsr_next  = {ramp_index_reg[DATA_W-3:0], 2'b01};
                                end
                                else if (cruise_left_reg != '0)
                                begin
                                    mode_next     = MODE_CRUISE;
                                    div_used_next = 1'b0;
                                end
                                else
                                begin
                                    mode_next     = MODE_DECEL;
                                    div_used_next = 1'b1;
                                    div_dsr_next  = {ramp_index_reg[DATA_W-3:0], 2'b00}
                                                    - DATA_W'(1);
                                end

                                div_rem_next = '0;
                                div_quo_next = dividend;
                                div_cnt_next = '1;

                                if (((accel_left_reg != '0) && (ramp_index_reg != '0))
                                    || ((accel_left_reg == '0) && (cruise_left_reg == '0)))
                                begin
                                    state_next = ST_DIV;
                                end
                                else
                                begin
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                        default:
                        begin
                            // unused command code, no effect
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                if (!trial_diff[DATA_W])
                begin
                    div_rem_next = trial_diff[DATA_W-1:0];
                    div_quo_next = {div_quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = trial[DATA_W-1:0];
                    div_quo_next = {div_quo_reg[DATA_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                    case (mode_reg)
                        MODE_DONE:
                        begin
                            result_next.step_bits    = '0;
                            result_next.delay_cycles = '0;
                            result_next.segment_done = 1'b1;
                        end
                        MODE_ACCEL:
                        begin
                            ramp_period_next = period_accel;
                            if (div_used_reg)
                            begin
                                ramp_remainder_next = div_rem_reg;
                            end
                            ramp_index_next          = ramp_index_reg + DATA_W'(1);
                            accel_left_next          = accel_left_reg - DATA_W'(1);
                            result_next.step_bits    = steps_reg;
                            result_next.delay_cycles = period_accel >> DELAY_SHIFT;
                            result_next.segment_done = 1'b0;
                        end
                        MODE_CRUISE:
                        begin
                            cruise_left_next         = cruise_left_reg - DATA_W'(1);
                            result_next.step_bits    = steps_reg;
                            result_next.delay_cycles = cruise_delay_reg;
                            result_next.segment_done = 1'b0;
                        end
                        MODE_DECEL:
                        begin
                            ramp_period_next         = period_decel;
                            ramp_remainder_next      = div_rem_reg;
                            ramp_index_next          = ramp_index_reg - DATA_W'(1);
                            decel_left_next          = decel_left_reg - DATA_W'(1);
                            result_next.step_bits    = steps_reg;
                            result_next.delay_cycles = period_decel >> DELAY_SHIFT;
                            result_next.segment_done = 1'b0;
                        end
                        default:
                        begin
                            result_next.step_bits    = '0;
                            result_next.delay_cycles = '0;
                            result_next.segment_done = 1'b1;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and ramp state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_DONE;
            div_used_reg       <= 1'b0;
            div_cnt_reg        <= '0;
            result_valid_reg   <= 1'b0;
            ramp_remainder_reg <= '0;
            ramp_period_reg    <= '0;
            ramp_index_reg     <= '0;
            accel_left_reg     <= '0;
            cruise_left_reg    <= '0;
            decel_left_reg     <= '0;
            cruise_delay_reg   <= '0;
            for (int i = 0; i < MOTORS; i++)
            begin
                phase_acc_reg[i]  <= '0;
                motor_rate_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg           <= mode_next;
            div_used_reg       <= div_used_next;
            div_cnt_reg        <= div_cnt_next;
            result_valid_reg   <= result_valid_next;
            ramp_remainder_reg <= ramp_remainder_next;
            ramp_period_reg    <= ramp_period_next;
            ramp_index_reg     <= ramp_index_next;
            accel_left_reg     <= accel_left_next;
            cruise_left_reg    <= cruise_left_next;
            decel_left_reg     <= decel_left_next;
            cruise_delay_reg   <= cruise_delay_next;
            for (int i = 0; i < MOTORS; i++)
            begin
                phase_acc_reg[i]  <= phase_acc_next[i];
                motor_rate_reg[i] <= motor_rate_next[i];
            end
        end
    end

    // divider and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_dsr_reg <= div_dsr_next;
        steps_reg   <= steps_next;
        result_reg  <= result_next;
    end

`include "stepper_segment_ramp_generator_top_macros.svh"

    // divider partial remainder stays below the divisor
    `SSRG_ASSERT_IMP(a_div_rem_bound, state_reg == ST_DIV, div_rem_reg < div_dsr_reg)

    // last divide pass hands over to emit
    `SSRG_ASSERT_NXT(a_div_to_emit, state_reg == ST_DIV && div_cnt_reg == '0,
                     state_reg == ST_EMIT)

    // step on a finished segment goes straight to a done result
    `SSRG_ASSERT_NXT(a_done_path, accept && item.command == CMD_STEP && all_zero,
                     state_reg == ST_EMIT && mode_reg == MODE_DONE)

    // emit with a free output slot loads the result and returns to idle
    `SSRG_ASSERT_NXT(a_emit_load, state_reg == ST_EMIT && out_free,
                     result_valid_reg && state_reg == ST_IDLE)

    // done result carries no steps and no delay
    `SSRG_ASSERT_IMP(a_done_zero, result_valid_reg && result_reg.segment_done,
                     result_reg.step_bits == '0 && result_reg.delay_cycles == '0)

endmodule
